// ----- rtl/altls_pkg.sv -----
// ----------------------------------------------------------------------------
// Allocation tracker package
// Shared sizes, field widths and request and status codes of the tracker.
// ----------------------------------------------------------------------------
package altls_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SIZE_BITS     = 24;

  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 32;
  localparam int TIME_W   = 48;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 7;
  localparam int CNT_W    = 32;
  localparam int LEAK_W   = 8;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 216;

  localparam int ENTRY_W = ADDR_W + SIZE_BITS + TIME_W;

  localparam int          MS_DIVISOR = 1000;
  localparam logic [31:0] AGE_RESET  = 32'd30000;

  typedef enum logic [CMD_W-1:0] {
    CMD_RECORD  = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_SCAN    = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_RECORDED  = 3'd0,
    STS_FULL      = 3'd1,
    STS_FAILED    = 3'd2,
    STS_RELEASED  = 3'd3,
    STS_UNTRACKED = 3'd4,
    STS_NULL      = 3'd5,
    STS_SCAN_DONE = 3'd6
  } status_t;

endpackage

// ----- rtl/altls_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module altls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/allocation_tracker_leak_scan.sv -----
// ----------------------------------------------------------------------------
// Allocation tracker with leak scan
// Table of live allocations held in a RAM and walked one entry per cycle.
// ----------------------------------------------------------------------------
// A failed or null request goes straight to the emit state; a record searches
// the valid bits for a free slot, and a release or a scan walks the entry RAM
// through its read port, one entry per cycle. One request is in flight at a time.
// Reset clears the valid bits, counters and scan totals directly; there is
// no clearing pass, and the age threshold returns to 30000 ms.
module allocation_tracker_leak_scan (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // command[1:0], address[33:2], block_size[57:34], now_us[105:58], zero pad
  input  logic [altls_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status[2:0], slot[9:3], alloc_count[41:10], free_count[73:42],
  // failures[105:74], bytes_in_use[137:106], peak_bytes[169:138],
  // leak_count[177:170], leaked_bytes[209:178], zero pad
  output logic [altls_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [31:0]                       cfg_wr_data
);

  import altls_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_WALK,
    ST_EMIT
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t                 state_r;
  logic [31:0]            cfg_age_r;
  cmd_t                   cmd_r;
  logic [ADDR_W-1:0]      addr_r;
  logic [SIZE_BITS-1:0]   size_r;
  logic [TIME_W-1:0]      now_r;
  logic [TIME_W-1:0]      thr_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   issue_done_r;
  logic                   pv_r;
  logic [IDX_W-1:0]       pidx_r;
  logic [IDX_W-1:0]       slot_r;
  logic [SIZE_BITS-1:0]   fsize_r;
  status_t                status_r;
  logic [LEAK_W-1:0]      acc_cnt_r;
  logic [CNT_W-1:0]       acc_bytes_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic [CNT_W-1:0]       alloc_r;
  logic [CNT_W-1:0]       free_r;
  logic [CNT_W-1:0]       fail_r;
  logic [CNT_W-1:0]       inuse_r;
  logic [CNT_W-1:0]       peak_r;
  logic [LEAK_W-1:0]      lcnt_r;
  logic [CNT_W-1:0]       lbytes_r;

  logic                   out_tvalid_r;
  status_t                o_status_r;
  logic [SLOT_W-1:0]      o_slot_r;
  logic [CNT_W-1:0]       o_alloc_r;
  logic [CNT_W-1:0]       o_free_r;
  logic [CNT_W-1:0]       o_fail_r;
  logic [CNT_W-1:0]       o_inuse_r;
  logic [CNT_W-1:0]       o_peak_r;
  logic [LEAK_W-1:0]      o_lcnt_r;
  logic [CNT_W-1:0]       o_lbytes_r;

  logic [CNT_W-1:0]       alloc_nxt;
  logic [CNT_W-1:0]       free_nxt;
  logic [CNT_W-1:0]       fail_nxt;
  logic [CNT_W-1:0]       inuse_nxt;
  logic [CNT_W-1:0]       peak_nxt;
  logic [LEAK_W-1:0]      lcnt_nxt;
  logic [CNT_W-1:0]       lbytes_nxt;

  cmd_t                   in_cmd;
  logic [ADDR_W-1:0]      in_addr;
  logic [SIZE_BITS-1:0]   in_size;
  logic [TIME_W-1:0]      in_now;

  logic                   emit_go;
  logic                   ram_we;
  logic                   ram_re;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [ADDR_W-1:0]      rd_addr_f;
  logic [SIZE_BITS-1:0]   rd_size_f;
  logic [TIME_W-1:0]      rd_time_f;
  logic [TIME_W-1:0]      age_us;
  logic                   p_valid;
  logic                   p_match;
  logic                   p_leak;
  logic                   p_last;
  logic [CNT_W-1:0]       inuse_add;

  assign in_cmd  = cmd_t'(in_tdata[1:0]);
  assign in_addr = in_tdata[33:2];
  assign in_size = in_tdata[57:34];
  assign in_now  = in_tdata[105:58];

  assign in_tready = (state_r == ST_IDLE);
  assign emit_go   = (state_r == ST_EMIT) && (!out_tvalid_r || out_tready);

  assign ram_we    = emit_go && (status_r == STS_RECORDED);
  assign ram_wdata = {now_r, size_r, addr_r};
  assign ram_re    = (state_r == ST_WALK) && !issue_done_r;

  altls_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (slot_r),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (idx_r),
    .rd_data (ram_rdata)
  );

  assign rd_addr_f = ram_rdata[ADDR_W-1:0];
  assign rd_size_f = ram_rdata[ADDR_W+SIZE_BITS-1:ADDR_W];
  assign rd_time_f = ram_rdata[ENTRY_W-1:ADDR_W+SIZE_BITS];

  // An entry is older than the threshold when its age in microseconds reaches
  // (threshold + 1) * 1000, which avoids dividing the age.
  assign age_us  = now_r - rd_time_f;
  assign p_valid = pv_r && valid_r[pidx_r];
  assign p_match = p_valid && (rd_addr_f == addr_r);
  assign p_leak  = p_valid && (age_us >= thr_r);
  assign p_last  = (pidx_r == LAST_IDX);

  assign inuse_add = inuse_r + CNT_W'(size_r);

  always_comb begin
    alloc_nxt  = alloc_r;
    free_nxt   = free_r;
    fail_nxt   = fail_r;
    inuse_nxt  = inuse_r;
    peak_nxt   = peak_r;
    lcnt_nxt   = lcnt_r;
    lbytes_nxt = lbytes_r;
    case (status_r)
      STS_RECORDED: begin
        alloc_nxt = alloc_r + CNT_W'(1);
        inuse_nxt = inuse_add;
        peak_nxt  = (inuse_add > peak_r) ? inuse_add : peak_r;
      end
      STS_FAILED: begin
        fail_nxt = fail_r + CNT_W'(1);
      end
      STS_RELEASED: begin
        free_nxt  = free_r + CNT_W'(1);
        inuse_nxt = inuse_r - CNT_W'(fsize_r);
      end
      STS_SCAN_DONE: begin
        lcnt_nxt   = acc_cnt_r;
        lbytes_nxt = acc_bytes_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cfg_age_r    <= AGE_RESET;
      valid_r      <= '0;
      alloc_r      <= '0;
      free_r       <= '0;
      fail_r       <= '0;
      inuse_r      <= '0;
      peak_r       <= '0;
      lcnt_r       <= '0;
      lbytes_r     <= '0;
      out_tvalid_r <= 1'b0;
      pv_r         <= 1'b0;
      issue_done_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_age_r <= cfg_wr_data;
      end
      if (out_tvalid_r && out_tready && !emit_go) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            cmd_r        <= in_cmd;
            addr_r       <= in_addr;
            size_r       <= in_size;
            now_r        <= in_now;
            thr_r        <= (TIME_W'(cfg_age_r) + TIME_W'(1)) * TIME_W'(MS_DIVISOR);
            idx_r        <= '0;
            issue_done_r <= 1'b0;
            pv_r         <= 1'b0;
            slot_r       <= '0;
            acc_cnt_r    <= '0;
            acc_bytes_r  <= '0;
            case (in_cmd)
              CMD_RECORD: begin
                if (in_addr == '0) begin
                  status_r <= STS_FAILED;
                  state_r  <= ST_EMIT;
                end else begin
                  state_r <= ST_FIND;
                end
              end
              CMD_RELEASE: begin
                if (in_addr == '0) begin
                  status_r <= STS_NULL;
                  state_r  <= ST_EMIT;
                end else begin
                  state_r <= ST_WALK;
                end
              end
              CMD_SCAN: begin
                state_r <= ST_WALK;
              end
              default: begin
                status_r <= STS_NULL;
                state_r  <= ST_EMIT;
              end
            endcase
          end
        end

        ST_FIND: begin
          if (!valid_r[idx_r]) begin
            slot_r   <= idx_r;
            status_r <= STS_RECORDED;
            state_r  <= ST_EMIT;
          end else if (idx_r == LAST_IDX) begin
            status_r <= STS_FULL;
            state_r  <= ST_EMIT;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end

        ST_WALK: begin
          if (ram_re) begin
            if (idx_r == LAST_IDX) begin
              issue_done_r <= 1'b1;
            end else begin
              idx_r <= idx_r + IDX_W'(1);
            end
          end
          pv_r   <= ram_re;
          pidx_r <= idx_r;
          if (pv_r) begin
            if (cmd_r == CMD_RELEASE) begin
              if (p_match) begin
                slot_r   <= pidx_r;
                fsize_r  <= rd_size_f;
                status_r <= STS_RELEASED;
                state_r  <= ST_EMIT;
              end else if (p_last) begin
                status_r <= STS_UNTRACKED;
                state_r  <= ST_EMIT;
              end
            end else begin
              if (p_leak) begin
                if (acc_cnt_r != {LEAK_W{1'b1}}) begin
                  acc_cnt_r <= acc_cnt_r + LEAK_W'(1);
                end
                acc_bytes_r <= acc_bytes_r + CNT_W'(rd_size_f);
              end
              if (p_last) begin
                status_r <= STS_SCAN_DONE;
                state_r  <= ST_EMIT;
              end
            end
          end
        end

        ST_EMIT: begin
          if (emit_go) begin
            if (status_r == STS_RECORDED) begin
              valid_r[slot_r] <= 1'b1;
            end
            if (status_r == STS_RELEASED) begin
              valid_r[slot_r] <= 1'b0;
            end
            alloc_r      <= alloc_nxt;
            free_r       <= free_nxt;
            fail_r       <= fail_nxt;
            inuse_r      <= inuse_nxt;
            peak_r       <= peak_nxt;
            lcnt_r       <= lcnt_nxt;
            lbytes_r     <= lbytes_nxt;
            o_status_r   <= status_r;
            o_slot_r     <= SLOT_W'(slot_r);
            o_alloc_r    <= alloc_nxt;
            o_free_r     <= free_nxt;
            o_fail_r     <= fail_nxt;
            o_inuse_r    <= inuse_nxt;
            o_peak_r     <= peak_nxt;
            o_lcnt_r     <= lcnt_nxt;
            o_lbytes_r   <= lbytes_nxt;
            out_tvalid_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, o_lbytes_r, o_lcnt_r, o_peak_r, o_inuse_r, o_fail_r,
                       o_free_r, o_alloc_r, o_slot_r, o_status_r};

endmodule
